/* rtl/imu_complementary_tilt_filter_macros.svh */
// Assertion macros shared by the tilt filter RTL.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
`define IMUCTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IMUCTF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IMUCTF_ASSERT(lbl, prop, msg)
`define IMUCTF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/imuctf_pkg.sv */
// Package with constants, register codes and arithmetic helpers of the tilt filter.
`default_nettype none
package imuctf_pkg;

  // CORDIC iteration count, limited to the length of the arctangent table.
  localparam int CORDIC_STEPS   = 16;
  localparam int CORDIC_EFF     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam logic signed [26:0] Q16_180 = 27'sd11796480;

  // Divider geometry.
  localparam int DIV_W = 45;
  localparam logic [10:0] DEN_TEMP = 11'd340;
  localparam logic [10:0] DEN_RATE = 11'd131;
  localparam logic [10:0] DEN_MS   = 11'd1000;

  // Digit-wise division: three 15-bit digits, reciprocals ceil(2^35 / d).
  // A partial dividend stays below 2^25, so the quotient digit is exact.
  localparam int DIG_W  = 15;
  localparam int DIG_N  = 3;
  localparam int RCP_SH = 35;
  localparam logic [27:0] RCP_TEMP = 28'd101058055;
  localparam logic [27:0] RCP_RATE = 28'd262288080;
  localparam logic [27:0] RCP_MS   = 28'd34359739;

  // Configuration register codes.
  localparam logic [2:0] REG_ACCEL_WEIGHT = 3'd0;
  localparam logic [2:0] REG_GYRO_WEIGHT  = 3'd1;
  localparam logic [2:0] REG_OFFSET_X     = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd3;
  localparam logic [2:0] REG_OFFSET_Z     = 3'd4;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  // Arctangent of 2^-i in degrees, Q.16.
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Absolute value of a 16-bit signed word.
  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? (17'd0 - e) : e;
  endfunction

  // Saturate to 32-bit signed.
  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    logic signed [31:0] r;
    if (v > 56'sd2147483647) r = 32'sh7fffffff;
    else if (v < -56'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Divide by 65536, rounding to nearest with ties away from zero.
  function automatic logic signed [55:0] rnd_shr16(input logic signed [55:0] s);
    logic [55:0] mag;
    logic [55:0] m;
    mag = s[55] ? (56'd0 - s) : s;
    m   = (mag + 56'd32768) >> 16;
    return s[55] ? $signed(56'd0 - m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

/* rtl/imuctf_if.sv */
// Valid/ready channel interfaces for the sample input and the result output.
`default_nettype none
interface imuctf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [15:0] temp_raw;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic [15:0]        elapsed_ms;
  logic               first_sample;
  modport source(output valid, acc_x, acc_y, acc_z, temp_raw, rate_x, rate_y, rate_z,
                 elapsed_ms, first_sample, input ready);
  modport sink(input valid, acc_x, acc_y, acc_z, temp_raw, rate_x, rate_y, rate_z,
               elapsed_ms, first_sample, output ready);
endinterface

interface imuctf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tilt_x;
  logic signed [31:0] tilt_y;
  logic signed [31:0] heading_z;
  logic signed [31:0] gyro_angle_x;
  logic signed [31:0] gyro_angle_y;
  logic signed [24:0] accel_angle_x;
  logic signed [24:0] accel_angle_y;
  logic signed [16:0] temp_c;
  modport source(output valid, tilt_x, tilt_y, heading_z, gyro_angle_x, gyro_angle_y,
                 accel_angle_x, accel_angle_y, temp_c, input ready);
  modport sink(input valid, tilt_x, tilt_y, heading_z, gyro_angle_x, gyro_angle_y,
               accel_angle_x, accel_angle_y, temp_c, output ready);
endinterface
`default_nettype wire

/* rtl/imuctf_cordic.sv */
// Iterative CORDIC vectoring unit computing atan2 in degrees, one rotation per cycle.
`default_nettype none
module imuctf_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] y_i,
  input  wire logic signed [17:0] x_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [24:0]      ang_o
);
  import imuctf_pkg::*;

  logic signed [30:0] x_q, y_q;
  logic signed [26:0] z_q;
  logic [4:0]         i_q;
  logic               busy_q, done_q;
  logic signed [24:0] ang_q;

  logic signed [30:0] xs, ys, xsh, ysh;
  logic signed [26:0] at;

  // Operand setup: sign-extended operands, shifted terms and the step's arctangent.
  always_comb begin
    xs  = {{13{x_i[17]}}, x_i};
    ys  = {{15{y_i[15]}}, y_i};
    xsh = x_q >>> i_q;
    ysh = y_q >>> i_q;
    at  = $signed({5'd0, atan_tab(i_q)});
  end

  // Rotation sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      ang_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        i_q <= '0;
        if (x_i == '0 && y_i == '0) begin
          ang_q  <= '0;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          if (x_i < 0) begin
            z_q <= (y_i >= 0) ? Q16_180 : -Q16_180;
            x_q <= (-xs) <<< 12;
            y_q <= (-ys) <<< 12;
          end else begin
            z_q <= '0;
            x_q <= xs <<< 12;
            y_q <= ys <<< 12;
          end
        end
      end else if (busy_q) begin
        if (i_q == 5'(CORDIC_EFF)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          if (z_q > Q16_180) ang_q <= Q16_180[24:0];
          else if (z_q < -Q16_180) ang_q <= 25'(-Q16_180);
          else ang_q <= z_q[24:0];
        end else begin
          i_q <= i_q + 5'd1;
          if (y_q > 0) begin
            x_q <= x_q + ysh;
            y_q <= y_q - xsh;
            z_q <= z_q + at;
          end else begin
            x_q <= x_q - ysh;
            y_q <= y_q + xsh;
            z_q <= z_q - at;
          end
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign ang_o  = ang_q;
endmodule
`default_nettype wire

/* rtl/imuctf_div.sv */
// Divider by a small constant using reciprocal multiplication on 15-bit digits, rounding to nearest.
`default_nettype none
module imuctf_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [imuctf_pkg::DIV_W-1:0] num_i,
  input  wire logic [10:0]                  den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [imuctf_pkg::DIV_W-1:0] quo_o
);
  import imuctf_pkg::*;

  logic [DIV_W-1:0] dvd_q, quo_q;
  logic [9:0]       rem_q;
  logic [24:0]      v_q;
  logic [14:0]      dig_q;
  logic [10:0]      den_q;
  logic [27:0]      rcp_q;
  logic [1:0]       cnt_q;
  logic             ph_q, neg_q, busy_q, done_q;

  logic [DIV_W-1:0] mag;
  logic [27:0]      rcp;
  logic [24:0]      v;
  logic [52:0]      prod;
  logic [25:0]      dprod;
  logic [25:0]      rem_full;

  // Magnitude plus half the divisor, reciprocal of the divisor, and the digit step.
  always_comb begin
    mag = (num_i[DIV_W-1] ? (DIV_W'(0) - num_i) : num_i) + DIV_W'(den_i >> 1);
    unique case (den_i)
      DEN_TEMP: rcp = RCP_TEMP;
      DEN_RATE: rcp = RCP_RATE;
      default:  rcp = RCP_MS;
    endcase
    v        = {rem_q, dvd_q[DIV_W-1 -: DIG_W]};
    prod     = {28'd0, v} * {25'd0, rcp_q};
    dprod    = {11'd0, dig_q} * {15'd0, den_q};
    rem_full = {1'b0, v_q} - dprod;
  end

  // Each digit is worked in phases: first the quotient digit, then the remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      ph_q   <= 1'b0;
      neg_q  <= 1'b0;
      dvd_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      v_q    <= '0;
      dig_q  <= '0;
      den_q  <= '0;
      rcp_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        ph_q   <= 1'b0;
        neg_q  <= num_i[DIV_W-1];
        dvd_q  <= mag;
        quo_q  <= '0;
        rem_q  <= '0;
        den_q  <= den_i;
        rcp_q  <= rcp;
      end else if (busy_q) begin
        if (!ph_q) begin
          v_q   <= v;
          dig_q <= prod[RCP_SH +: DIG_W];
          dvd_q <= dvd_q << DIG_W;
          ph_q  <= 1'b1;
        end else begin
          rem_q <= rem_full[9:0];
          quo_q <= {quo_q[DIV_W-DIG_W-1:0], dig_q};
          ph_q  <= 1'b0;
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'(DIG_N - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? $signed(DIV_W'(0) - quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

/* rtl/imu_complementary_tilt_filter.sv */
// Complementary tilt filter top level: sequencer, shared multiplier and state.
//
// Usage: one IMU sample transaction enters on in_i (valid/ready); one result
// transaction leaves on out_o. Configuration writes use cfg_we_i, cfg_idx_i and
// cfg_wdata_i and are taken at any clock edge with cfg_we_i high; write only
// while the block is idle.
// Sequence: two CORDIC runs of 16 steps, which skip the rotations when both
// operands are zero, then the shared divider runs seven divisions (temperature,
// three gyro scalings, three time scalings) between multiply and update steps;
// a seeding sample skips the blend. Ready is high only while idle, so a new
// sample is taken only once the last one has left the sequencer.
// The result sits in an output register, so a new sample is accepted while a
// finished result waits; if the receiver still stalls when the next result is
// done, the sequencer holds until the output register frees up.
// Reset: rst_ni clears the filter state, the integrals and the output valid,
// and loads the default weights (1311 and 64225) and zero gyro biases.
`default_nettype none
`include "imu_complementary_tilt_filter_macros.svh"
module imu_complementary_tilt_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [25:0] cfg_wdata_i,
  imuctf_in_if.sink        in_i,
  imuctf_out_if.source     out_o
);
  import imuctf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CORA, ST_CORA_W, ST_CORB, ST_CORB_W, ST_TEMP, ST_TEMP_W,
    ST_RATE, ST_RATE_W, ST_MUL, ST_INC, ST_INC_W, ST_UPD,
    ST_BL1, ST_BL2, ST_BL3, ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [16:0]        aw_q, gw_q;
  logic signed [25:0] off_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q     <= 17'd1311;
      gw_q     <= 17'd64225;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_WEIGHT: aw_q     <= cfg_wdata_i[16:0];
        REG_GYRO_WEIGHT:  gw_q     <= cfg_wdata_i[16:0];
        REG_OFFSET_X:     off_q[0] <= cfg_wdata_i;
        REG_OFFSET_Y:     off_q[1] <= cfg_wdata_i;
        REG_OFFSET_Z:     off_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Captured sample.
  logic signed [15:0] ax_q, ay_q, az_q, traw_q;
  logic signed [15:0] g_q [3];
  logic [15:0]        ms_q;
  logic               first_q;

  // Working registers and filter state.
  logic [1:0]         k_q;
  logic signed [24:0] accx_q, accy_q;
  logic signed [16:0] temp_q;
  logic signed [26:0] r_q;
  logic signed [33:0] inc_q [3];
  logic signed [53:0] prod_q, p1_q;
  logic signed [31:0] filt_q [2];
  logic signed [31:0] integ_q [3];

  // Result register.
  logic               out_valid_q;
  logic signed [31:0] o_tx_q, o_ty_q, o_hz_q, o_gx_q, o_gy_q;
  logic signed [24:0] o_ax_q, o_ay_q;
  logic signed [16:0] o_tc_q;

  // Shared arithmetic units.
  logic                     cor_start, cor_busy, cor_done;
  logic signed [15:0]       cor_y;
  logic signed [17:0]       cor_x;
  logic signed [24:0]       cor_ang;
  logic                     div_start, div_busy, div_done;
  logic signed [DIV_W-1:0]  div_num, div_quo;
  logic [10:0]              div_den;
  logic signed [35:0]       mul_a;
  logic signed [17:0]       mul_b;
  logic signed [53:0]       mul_p;
  logic signed [16:0]       t17;
  logic signed [34:0]       fsum;
  logic [16:0]              aw_eff, gw_eff;
  logic signed [55:0]       bsum;
  logic                     in_acc, out_free;

  imuctf_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start), .y_i(cor_y), .x_i(cor_x),
    .busy_o(cor_busy), .done_o(cor_done), .ang_o(cor_ang)
  );

  imuctf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  // Operand selection for the CORDIC, divider and multiplier.
  always_comb begin
    in_acc    = in_i.valid && in_i.ready;
    out_free  = !out_valid_q || out_o.ready;
    cor_start = (state_q == ST_CORA) || (state_q == ST_CORB);
    cor_y     = (state_q == ST_CORA) ? ay_q : ax_q;
    cor_x     = {{2{az_q[15]}}, az_q} +
                {1'b0, abs16((state_q == ST_CORA) ? ax_q : ay_q)};
    aw_eff    = (aw_q > WEIGHT_ONE) ? WEIGHT_ONE : aw_q;
    gw_eff    = (gw_q > WEIGHT_ONE) ? WEIGHT_ONE : gw_q;
    t17       = {traw_q[15], traw_q} + 17'sd12412;
    fsum      = {{3{filt_q[k_q[0]][31]}}, filt_q[k_q[0]]} +
                {inc_q[k_q][33], inc_q[k_q]};
    div_start = (state_q == ST_TEMP) || (state_q == ST_RATE) || (state_q == ST_INC);
    case (state_q)
      ST_TEMP: begin
        div_num = {{20{t17[16]}}, t17, 8'd0};
        div_den = DEN_TEMP;
      end
      ST_RATE: begin
        div_num = {{12{g_q[k_q][15]}}, g_q[k_q], 17'd0};
        div_den = DEN_RATE;
      end
      default: begin
        div_num = prod_q[DIV_W-1:0];
        div_den = DEN_MS;
      end
    endcase
    case (state_q)
      ST_BL1: begin
        mul_a = {fsum[34], fsum};
        mul_b = {1'b0, gw_eff};
      end
      ST_BL2: begin
        mul_a = {{11{(k_q[0] ? accy_q[24] : accx_q[24])}}, (k_q[0] ? accy_q : accx_q)};
        mul_b = {1'b0, aw_eff};
      end
      default: begin
        mul_a = {{9{r_q[26]}}, r_q};
        mul_b = {2'b00, ms_q};
      end
    endcase
    mul_p = mul_a * mul_b;
    bsum  = rnd_shr16({{2{p1_q[53]}}, p1_q} + {{2{prod_q[53]}}, prod_q});
  end

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      filt_q[0]   <= '0;
      filt_q[1]   <= '0;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      integ_q[2]  <= '0;
    end else begin
      // A result taken by the receiver frees the output register, unless a new one lands.
      if (out_valid_q && out_o.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            ax_q    <= in_i.acc_x;
            ay_q    <= in_i.acc_y;
            az_q    <= in_i.acc_z;
            traw_q  <= in_i.temp_raw;
            g_q[0]  <= in_i.rate_x;
            g_q[1]  <= in_i.rate_y;
            g_q[2]  <= in_i.rate_z;
            ms_q    <= in_i.elapsed_ms;
            first_q <= in_i.first_sample;
            state_q <= ST_CORA;
          end
        end
        ST_CORA: state_q <= ST_CORA_W;
        ST_CORA_W: begin
          if (cor_done) begin
            accx_q  <= cor_ang;
            state_q <= ST_CORB;
          end
        end
        ST_CORB: state_q <= ST_CORB_W;
        ST_CORB_W: begin
          if (cor_done) begin
            accy_q  <= -cor_ang;
            state_q <= ST_TEMP;
          end
        end
        ST_TEMP: state_q <= ST_TEMP_W;
        ST_TEMP_W: begin
          if (div_done) begin
            temp_q  <= div_quo[16:0];
            k_q     <= '0;
            state_q <= ST_RATE;
          end
        end
        ST_RATE: state_q <= ST_RATE_W;
        ST_RATE_W: begin
          if (div_done) begin
            r_q     <= div_quo[26:0] - {off_q[k_q][25], off_q[k_q]};
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= mul_p;
          state_q <= ST_INC;
        end
        ST_INC: state_q <= ST_INC_W;
        ST_INC_W: begin
          if (div_done) begin
            inc_q[k_q] <= div_quo[33:0];
            if (k_q == 2'd2) begin
              state_q <= ST_UPD;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= ST_RATE;
            end
          end
        end
        ST_UPD: begin
          integ_q[2] <= sat32({{24{integ_q[2][31]}}, integ_q[2]} +
                              {{22{inc_q[2][33]}}, inc_q[2]});
          k_q <= '0;
          if (first_q) begin
            integ_q[0] <= '0;
            integ_q[1] <= '0;
            filt_q[0]  <= {{7{accx_q[24]}}, accx_q};
            filt_q[1]  <= {{7{accy_q[24]}}, accy_q};
            state_q    <= ST_DONE;
          end else begin
            integ_q[0] <= sat32({{24{integ_q[0][31]}}, integ_q[0]} +
                                {{22{inc_q[0][33]}}, inc_q[0]});
            integ_q[1] <= sat32({{24{integ_q[1][31]}}, integ_q[1]} +
                                {{22{inc_q[1][33]}}, inc_q[1]});
            state_q    <= ST_BL1;
          end
        end
        ST_BL1: begin
          prod_q  <= mul_p;
          state_q <= ST_BL2;
        end
        ST_BL2: begin
          p1_q    <= prod_q;
          prod_q  <= mul_p;
          state_q <= ST_BL3;
        end
        ST_BL3: begin
          filt_q[k_q[0]] <= sat32(bsum);
          if (k_q == 2'd1) begin
            state_q <= ST_DONE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_BL1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            o_tx_q      <= filt_q[0];
            o_ty_q      <= filt_q[1];
            o_hz_q      <= integ_q[2];
            o_gx_q      <= integ_q[0];
            o_gy_q      <= integ_q[1];
            o_ax_q      <= accx_q;
            o_ay_q      <= accy_q;
            o_tc_q      <= temp_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.tilt_x        = o_tx_q;
  assign out_o.tilt_y        = o_ty_q;
  assign out_o.heading_z     = o_hz_q;
  assign out_o.gyro_angle_x  = o_gx_q;
  assign out_o.gyro_angle_y  = o_gy_q;
  assign out_o.accel_angle_x = o_ax_q;
  assign out_o.accel_angle_y = o_ay_q;
  assign out_o.temp_c        = o_tc_q;

  // Units start only when free, results are always published, ready is low while busy.
  `IMUCTF_ASSERT(a_cor_free, cor_start |-> !cor_busy, "CORDIC started while busy")
  `IMUCTF_ASSERT(a_div_free, div_start |-> !div_busy, "divider started while busy")
  `IMUCTF_ASSERT(a_publish, (state_q == ST_DONE && out_free) |=> out_valid_q,
                 "result not published")
  `IMUCTF_ASSERT(a_busy_units, (cor_busy || div_busy) |-> !in_i.ready,
                 "sample accepted while a unit is busy")
endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the complementary tilt filter: drives samples, predicts and checks results.
`default_nettype none
module testbench;
  import imuctf_pkg::*;

  typedef struct {
    logic signed [15:0] acc_x, acc_y, acc_z, temp_raw, rate_x, rate_y, rate_z;
    logic [15:0]        elapsed_ms;
    logic               first_sample;
  } sample_t;

  typedef struct {
    logic signed [31:0] tilt_x, tilt_y, heading_z, gyro_angle_x, gyro_angle_y;
    logic signed [24:0] accel_angle_x, accel_angle_y;
    logic signed [16:0] temp_c;
  } angles_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [25:0] cfg_wdata_i;

  imuctf_in_if  in_ch();
  imuctf_out_if out_ch();

  imu_complementary_tilt_filter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  // Predictor state and its copy of the registers.
  longint  w_accel, w_gyro, bias_x, bias_y, bias_z;
  longint  filt_x, filt_y, integ_x, integ_y, integ_z;

  sample_t pending_samples[$];
  angles_t expected_angles[$];
  int      error_count;
  int      send_idle_pct, recv_stall_pct;
  bit      stimulus_done;

  // Arctangent table in degrees Q.16.
  longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                           14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Round to nearest, ties away from zero.
  function automatic longint div_round(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint tilt_atan2(longint y, longint x);
    longint z, xo;
    int steps;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
      x = -x;
      y = -y;
    end
    x = x * 4096;
    y = y * 4096;
    for (int i = 0; i < steps; i++) begin
      xo = x;
      if (y > 0) begin
        x = x + shift_floor(y, i);
        y = y - shift_floor(xo, i);
        z = z + atan_deg[i];
      end else begin
        x = x - shift_floor(y, i);
        y = y + shift_floor(xo, i);
        z = z - atan_deg[i];
      end
    end
    if (z > 64'sd11796480) z = 64'sd11796480;
    if (z < -64'sd11796480) z = -64'sd11796480;
    return z;
  endfunction

  function automatic longint blend_angle(longint prev, longint inc, longint acc);
    longint aw, gw;
    aw = (w_accel > 65536) ? 65536 : w_accel;
    gw = (w_gyro > 65536) ? 65536 : w_gyro;
    return clamp32(div_round(gw * (prev + inc) + aw * acc, 65536));
  endfunction

  // Advance the predictor by one sample and queue the expected angles.
  task automatic predict_angles(sample_t s);
    longint ax, ay, az, ang_x, ang_y, rx, ry, rz, ms;
    angles_t e;
    ax = s.acc_x; ay = s.acc_y; az = s.acc_z;
    ms = s.elapsed_ms;
    ang_x = tilt_atan2(ay, az + (ax < 0 ? -ax : ax));
    ang_y = -tilt_atan2(ax, az + (ay < 0 ? -ay : ay));
    rx = div_round(longint'(s.rate_x) * 131072, 131) - bias_x;
    ry = div_round(longint'(s.rate_y) * 131072, 131) - bias_y;
    rz = div_round(longint'(s.rate_z) * 131072, 131) - bias_z;
    integ_z = clamp32(integ_z + div_round(rz * ms, 1000));
    if (s.first_sample) begin
      integ_x = 0;
      integ_y = 0;
      filt_x = ang_x;
      filt_y = ang_y;
    end else begin
      integ_x = clamp32(integ_x + div_round(rx * ms, 1000));
      integ_y = clamp32(integ_y + div_round(ry * ms, 1000));
      filt_x = blend_angle(filt_x, div_round(rx * ms, 1000), ang_x);
      filt_y = blend_angle(filt_y, div_round(ry * ms, 1000), ang_y);
    end
    e.tilt_x = filt_x[31:0];
    e.tilt_y = filt_y[31:0];
    e.heading_z = integ_z[31:0];
    e.gyro_angle_x = integ_x[31:0];
    e.gyro_angle_y = integ_y[31:0];
    e.accel_angle_x = ang_x[24:0];
    e.accel_angle_y = ang_y[24:0];
    e.temp_c = 17'(div_round((longint'(s.temp_raw) + 12412) * 256, 340));
    expected_angles.push_back(e);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Register write at one clock edge; predictor copy updated in step.
  task automatic write_reg(logic [2:0] idx, logic [25:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ACCEL_WEIGHT: w_accel = val[16:0];
      REG_GYRO_WEIGHT:  w_gyro = val[16:0];
      REG_OFFSET_X:     bias_x = longint'($signed(val));
      REG_OFFSET_Y:     bias_y = longint'($signed(val));
      REG_OFFSET_Z:     bias_z = longint'($signed(val));
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample(bit seed);
    sample_t s;
    s.acc_x = pick_word(); s.acc_y = pick_word(); s.acc_z = pick_word();
    s.temp_raw = 16'($urandom);
    s.rate_x = pick_word(); s.rate_y = pick_word(); s.rate_z = pick_word();
    case ($urandom_range(0, 3))
      0: s.elapsed_ms = 16'($urandom);
      1: s.elapsed_ms = 16'hffff;
      default: s.elapsed_ms = 16'($urandom_range(0, 20));
    endcase
    s.first_sample = seed;
    return s;
  endfunction

  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_angles.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready) predict_angles(pending_samples.pop_front());
      if (pending_samples.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid        <= 1'b1;
        in_ch.acc_x        <= pending_samples[0].acc_x;
        in_ch.acc_y        <= pending_samples[0].acc_y;
        in_ch.acc_z        <= pending_samples[0].acc_z;
        in_ch.temp_raw     <= pending_samples[0].temp_raw;
        in_ch.rate_x       <= pending_samples[0].rate_x;
        in_ch.rate_y       <= pending_samples[0].rate_y;
        in_ch.rate_z       <= pending_samples[0].rate_z;
        in_ch.elapsed_ms   <= pending_samples[0].elapsed_ms;
        in_ch.first_sample <= pending_samples[0].first_sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    angles_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          e = expected_angles.pop_front();
          if (out_ch.tilt_x !== e.tilt_x) report_mismatch("tilt_x", out_ch.tilt_x, e.tilt_x);
          if (out_ch.tilt_y !== e.tilt_y) report_mismatch("tilt_y", out_ch.tilt_y, e.tilt_y);
          if (out_ch.heading_z !== e.heading_z)
            report_mismatch("heading_z", out_ch.heading_z, e.heading_z);
          if (out_ch.gyro_angle_x !== e.gyro_angle_x)
            report_mismatch("gyro_angle_x", out_ch.gyro_angle_x, e.gyro_angle_x);
          if (out_ch.gyro_angle_y !== e.gyro_angle_y)
            report_mismatch("gyro_angle_y", out_ch.gyro_angle_y, e.gyro_angle_y);
          if (out_ch.accel_angle_x !== e.accel_angle_x)
            report_mismatch("accel_angle_x", out_ch.accel_angle_x, e.accel_angle_x);
          if (out_ch.accel_angle_y !== e.accel_angle_y)
            report_mismatch("accel_angle_y", out_ch.accel_angle_y, e.accel_angle_y);
          if (out_ch.temp_c !== e.temp_c) report_mismatch("temp_c", out_ch.temp_c, e.temp_c);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus: reset, directed samples, then random phases with register changes.
  initial begin
    sample_t s;
    int idle_sets[4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{21, 21}};
    logic signed [15:0] corner[5] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff};
    error_count = 0;
    stimulus_done = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    w_accel = 1311; w_gyro = 64225; bias_x = 0; bias_y = 0; bias_z = 0;
    filt_x = 0; filt_y = 0; integ_x = 0; integ_y = 0; integ_z = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ACCEL_WEIGHT;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.acc_x = '0; in_ch.acc_y = '0; in_ch.acc_z = '0; in_ch.temp_raw = '0;
    in_ch.rate_x = '0; in_ch.rate_y = '0; in_ch.rate_z = '0;
    in_ch.elapsed_ms = '0; in_ch.first_sample = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero operands, negative denominator with zero numerator, extremes.
    s = random_sample(1'b1);
    s.acc_x = 0; s.acc_y = 0; s.acc_z = 0; s.temp_raw = 16'sh8000;
    pending_samples.push_back(s);
    s.acc_z = -100; s.temp_raw = 16'sh7fff; s.first_sample = 0;
    pending_samples.push_back(s);
    foreach (corner[i]) begin
      s.acc_x = corner[i]; s.acc_y = corner[(i + 1) % 5]; s.acc_z = corner[(i + 2) % 5];
      s.rate_x = corner[i]; s.rate_y = corner[(i + 3) % 5]; s.rate_z = corner[i];
      s.temp_raw = corner[i];
      s.elapsed_ms = (i % 2) ? 16'hffff : 16'h0000;
      s.first_sample = (i == 2);
      pending_samples.push_back(s);
    end
    // Saturate the integrals with long intervals at full rate.
    for (int i = 0; i < 8; i++) begin
      s = random_sample(1'b0);
      s.rate_x = 16'sh7fff; s.rate_y = 16'sh8000; s.rate_z = 16'sh7fff;
      s.elapsed_ms = 16'hffff;
      pending_samples.push_back(s);
    end
    wait_idle();

    // Random phases, each with its own register setting and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_ACCEL_WEIGHT, 26'd0); write_reg(REG_GYRO_WEIGHT, 26'd65536); end
        1: begin write_reg(REG_ACCEL_WEIGHT, 26'h1ffff); write_reg(REG_GYRO_WEIGHT, 26'd0); end
        2: begin
          write_reg(REG_OFFSET_X, 26'h1ffffff); write_reg(REG_OFFSET_Y, 26'h2000000);
          write_reg(REG_OFFSET_Z, 26'h3ffffff);
        end
        3: begin
          write_reg(REG_ACCEL_WEIGHT, 26'd1311); write_reg(REG_GYRO_WEIGHT, 26'd64225);
          write_reg(REG_OFFSET_X, 26'($urandom)); write_reg(REG_OFFSET_Y, 26'($urandom));
          write_reg(REG_OFFSET_Z, 26'($urandom));
        end
        4: write_reg(3'd7, 26'($urandom));
        5: begin
          write_reg(REG_ACCEL_WEIGHT, 26'($urandom_range(0, 131071)));
          write_reg(REG_GYRO_WEIGHT, 26'($urandom_range(0, 131071)));
        end
        6: begin
          write_reg(REG_OFFSET_X, 26'd0); write_reg(REG_OFFSET_Y, 26'd0);
          write_reg(REG_OFFSET_Z, 26'd0);
        end
        default: write_reg(REG_GYRO_WEIGHT, 26'h3fe0000);
      endcase
      send_idle_pct = idle_sets[ph % 4][0];
      recv_stall_pct = idle_sets[ph % 4][1];
      // Mostly runs of normal samples, each run opened by a seeding sample.
      for (int i = 0; i < 92; i++)
        pending_samples.push_back(random_sample(i % 23 == 0 || $urandom_range(0, 49) == 0));
      wait_idle();
    end
    stimulus_done = 1;
  end

  // Final verdict.
  initial begin
    wait (stimulus_done);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

/* imu_complementary_tilt_filter.f */
+incdir+rtl
rtl/imuctf_pkg.sv
rtl/imuctf_if.sv
rtl/imuctf_cordic.sv
rtl/imuctf_div.sv
rtl/imu_complementary_tilt_filter.sv
test/testbench.sv
